@@ rtl/hst_pkg.sv @@
// hst_pkg: shared types and constants of the handle slot table
// request and response payloads, mode and status codes, controller commands
// no dependencies
package hst_pkg;

  // table capacity and derived widths
  localparam int unsigned SLOTS  = 64;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // request modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] handle;
    logic [6:0]  position;
    logic [63:0] object_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [63:0] object_out;
    logic [6:0]  next_position;
    logic [6:0]  occupied_count;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

@@ rtl/hst_ctrl.sv @@
// hst_ctrl: request sequencer of the handle slot table
// accepts a request, runs the execute state, then holds the response
// depends on hst_pkg
module hst_ctrl
  import hst_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_take;
  logic   accept;

  // a new request enters when idle or when the held response leaves
  assign can_take   = (state_q == S_IDLE) || ((state_q == S_RESP) && !out_stall_i);
  assign in_stall_o = !can_take;
  assign accept     = in_valid_i && can_take;

  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign out_valid_o = out_valid_q;

  // state and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q     <= S_RESP;
          out_valid_q <= 1'b1;
        end
        S_RESP: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= accept ? S_EXEC : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/hst_datapath.sv @@
// hst_datapath: slot memory, occupancy map, count and response registers
// performs add, remove, lookup and read by position on the exec command
// depends on hst_pkg
module hst_datapath
  import hst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output rsp_t        rsp_o
);

  // lowest clear bit of the occupancy map
  function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] map);
    logic [SLOT_W-1:0] lowest;
    lowest = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!map[i]) lowest = SLOT_W'(i);
    end
    return lowest;
  endfunction

  logic [63:0]       mem_q [SLOTS];
  req_t              req_q;
  logic [31:0]       base_q;
  logic [SLOTS-1:0]  map_q;
  logic [CNT_W-1:0]  count_q;
  logic [SLOT_W-1:0] free_idx_q;
  logic              free_ok_q;
  logic [1:0]        status_q;
  logic [31:0]       handle_q;
  logic [6:0]        next_pos_q;
  logic              show_q;
  logic              occ_q;
  logic [63:0]       rdata_q;

  logic [31:0]       offset;
  logic [31:0]       pos_ext;
  logic              handle_in_range;
  logic              pos_in_range;
  logic [SLOT_W-1:0] idx;
  logic              add_ok;
  logic              rem_ok;
  logic [1:0]        status_d;
  logic              show_d;

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // handle base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) base_q <= '0;
    else if (cfg_we_i) base_q <= cfg_wdata_i;
  end

  // free slot search, registered off the current map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_idx_q <= '0;
      free_ok_q  <= 1'b0;
    end else begin
      free_idx_q <= first_free(map_q);
      free_ok_q  <= !(&map_q);
    end
  end

  // address and range decode
  assign offset          = req_q.handle - base_q;
  assign pos_ext         = 32'(req_q.position);
  assign handle_in_range = offset < 32'(SLOTS);
  assign pos_in_range    = pos_ext < 32'(SLOTS);
  assign add_ok = (req_q.mode == MODE_ADD) && (req_q.object_word != '0) && free_ok_q;

  always_comb begin
    unique case (req_q.mode)
      MODE_ADD:    idx = free_idx_q;
      MODE_READ:   idx = pos_ext[SLOT_W-1:0];
      default:     idx = offset[SLOT_W-1:0];
    endcase
  end

  assign rem_ok = (req_q.mode == MODE_REMOVE) && handle_in_range && map_q[idx];

  // status and read qualification
  always_comb begin
    status_d = ST_OK;
    show_d   = 1'b0;
    unique case (req_q.mode)
      MODE_ADD: begin
        if (req_q.object_word == '0) status_d = ST_ZERO;
        else if (!free_ok_q)         status_d = ST_FULL;
      end
      MODE_REMOVE: begin
        if (!handle_in_range) status_d = ST_RANGE;
      end
      MODE_LOOKUP: begin
        if (!handle_in_range) status_d = ST_RANGE;
        else                  show_d   = 1'b1;
      end
      MODE_READ: begin
        if (!pos_in_range) status_d = ST_RANGE;
        else               show_d   = 1'b1;
      end
      default: status_d = ST_OK;
    endcase
  end

  // slot memory: write on add, registered read every exec
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (add_ok) mem_q[idx] <= req_q.object_word;
      rdata_q <= mem_q[idx];
    end
  end

  // occupancy map and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      if (add_ok) begin
        map_q[idx] <= 1'b1;
        count_q    <= count_q + CNT_W'(1);
      end else if (rem_ok) begin
        map_q[idx] <= 1'b0;
        count_q    <= count_q - CNT_W'(1);
      end
    end
  end

  // response registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q   <= status_d;
      handle_q   <= add_ok ? (32'(free_idx_q) + base_q) : '0;
      next_pos_q <= ((req_q.mode == MODE_READ) && pos_in_range) ?
                    (req_q.position + 7'd1) : '0;
      show_q     <= show_d;
      occ_q      <= map_q[idx];
    end
  end

  // an empty slot reads as zero
  assign rsp_o.status         = status_q;
  assign rsp_o.handle_out     = handle_q;
  assign rsp_o.object_out     = (show_q && occ_q) ? rdata_q : '0;
  assign rsp_o.next_position  = next_pos_q;
  assign rsp_o.occupied_count = 7'(count_q);

endmodule

@@ rtl/handle_slot_table.sv @@
// handle_slot_table: first-free handle table, top level
// joins the hst_ctrl sequencer and the hst_datapath, depends on hst_pkg
//
// Usage:
//   A request (mode, handle, position, object word) enters on in_valid_i
//   when in_stall_o is low. Add stores a nonzero word in the lowest free slot
//   and returns slot plus base as handle; remove frees a slot by handle;
//   lookup reads by handle; read by position walks the raw slots.
//   One response per request appears on out_valid_o after the execute state
//   and stays until out_stall_i is low. Each request passes an execute
//   state for the registered slot memory read and write, then a response
//   state in which the next request may enter as the response leaves.
//   The base register is written with cfg_we_i / cfg_wdata_i; the user must
//   write it only while idle, the block itself does not enforce this.
//   Reset clears the occupancy map, the count and the base;
//   the slot memory is masked by the map, so no clearing pass is needed.
//   While the receiver stalls, the response is held and no request enters.
module handle_slot_table
  import hst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  cmd_t cmd;

  hst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  hst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_rsp_o)
  );

`ifndef ASSERT_OFF
  // a taken request gets its response once the execute state is over
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)
    else $error("response not shown two cycles after request");

  // no response in the execute cycle
  a_exec_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("response shown during execute");

  // count never exceeds the capacity
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.occupied_count <= 7'(SLOTS)))
    else $error("occupied count above capacity");

  // a failed request returns no handle
  a_fail_handle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != ST_OK)) |-> (out_rsp_o.handle_out == '0))
    else $error("handle returned on failed request");
`endif

endmodule
